[rtl/primitive_signed_distance_weight_assert.svh]
// Assertion macros for the signed distance block.
// Included by the top level; needs nothing else.
`ifndef PRIMITIVE_SIGNED_DISTANCE_WEIGHT_ASSERT_SVH
`define PRIMITIVE_SIGNED_DISTANCE_WEIGHT_ASSERT_SVH

// Check that chk holds in the same cycle as cond.
`define PSDW_ASSERT_NOW(label, clk_sig, rst_sig, cond, chk, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |-> (chk)) \
    else $error(msg);

// Check that chk holds in the cycle after cond.
`define PSDW_ASSERT_NEXT(label, clk_sig, rst_sig, cond, chk, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |=> (chk)) \
    else $error(msg);

`endif

[rtl/psdw_pkg.sv]
// Shared types, codes and helpers of the signed distance block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psdw_pkg;

  localparam int SQRT_LAT = 32;
  localparam int DIV_QW   = 34;
  localparam int DIV_LAT  = DIV_QW + 1;

  localparam logic [31:0] EPS_RAW = 32'd6;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] KIND_BOX     = 2'd0;
  localparam logic [1:0] KIND_SPHERE  = 2'd1;
  localparam logic [1:0] KIND_CAPSULE = 2'd2;

  localparam logic [2:0] REG_SHAPE_KIND    = 3'd0;
  localparam logic [2:0] REG_BOX_SIZE_X    = 3'd1;
  localparam logic [2:0] REG_BOX_SIZE_Y    = 3'd2;
  localparam logic [2:0] REG_BOX_SIZE_Z    = 3'd3;
  localparam logic [2:0] REG_RADIUS        = 3'd4;
  localparam logic [2:0] REG_CAPSULE_H     = 3'd5;
  localparam logic [2:0] REG_BLEND_INSIDE  = 3'd6;
  localparam logic [2:0] REG_BLEND_OUTSIDE = 3'd7;

  localparam logic [1:0] NEAR_P     = 2'd0;
  localparam logic [1:0] NEAR_C     = 2'd1;
  localparam logic [1:0] NEAR_SCALE = 2'd2;
  localparam logic [1:0] NEAR_ZERO  = 2'd3;

  localparam logic [1:0] W_ONE     = 2'd0;
  localparam logic [1:0] W_ZERO    = 2'd1;
  localparam logic [1:0] W_IN_DIV  = 2'd2;
  localparam logic [1:0] W_OUT_DIV = 2'd3;

  localparam logic signed [35:0] MAX32 = 36'sd2147483647;
  localparam logic signed [35:0] MIN32 = -36'sd2147483648;

  // Carried alongside the square root.
  typedef struct packed {
    logic               is_sph;
    logic [2:0]         sgn;
    logic [31:0]        mag_x;
    logic [31:0]        mag_y;
    logic [31:0]        mag_z;
    logic signed [31:0] p_x;
    logic signed [31:0] p_y;
    logic signed [31:0] p_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic signed [33:0] box_m;
  } pre_t;

  // Carried alongside the dividers.
  typedef struct packed {
    logic               is_in;
    logic signed [31:0] sd;
    logic [1:0]         near_mode;
    logic [1:0]         w_mode;
    logic [2:0]         sgn;
    logic signed [31:0] p_x;
    logic signed [31:0] p_y;
    logic signed [31:0] p_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
  } post_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > MAX32) begin
      return 32'sh7FFFFFFF;
    end else if (v < MIN32) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

`default_nettype wire

[rtl/psdw_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on psdw_pkg for the stage count.
`timescale 1ns / 1ps
`default_nettype none

module psdw_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] din,
  output logic [31:0] root
);

  logic [63:0] rem_q  [psdw_pkg::SQRT_LAT];
  logic [63:0] root_q [psdw_pkg::SQRT_LAT];

  genvar i;
  generate
    for (i = 0; i < psdw_pkg::SQRT_LAT; i++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
      logic [63:0] in_rem;
      logic [63:0] in_root;
      logic [63:0] trial;
      logic        ge;
      if (i == 0) begin : g_first
        assign in_rem  = din;
        assign in_root = 64'd0;
      end else begin : g_rest
        assign in_rem  = rem_q[i-1];
        assign in_root = root_q[i-1];
      end
      assign trial = in_root + BIT;
      assign ge    = in_rem >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i]  <= ge ? in_rem - trial : in_rem;
          root_q[i] <= ge ? (in_root >> 1) + BIT : in_root >> 1;
        end
      end
    end
  endgenerate

  assign root = root_q[psdw_pkg::SQRT_LAT-1][31:0];

endmodule

`default_nettype wire

[rtl/psdw_div.sv]
// Pipelined rounding divider, one quotient bit per stage, with overflow flag.
// Depends on psdw_pkg for the quotient width.
`timescale 1ns / 1ps
`default_nettype none

module psdw_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [63:0]                 num,
  input  logic [31:0]                 den,
  output logic [psdw_pkg::DIV_QW-1:0] quo,
  output logic                        ovf
);

  localparam int QW = psdw_pkg::DIV_QW;

  logic [64:0]   rem_q [QW+1];
  logic [31:0]   den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  logic [64:0] npr;

  // Round to nearest: add half the divisor first.
  assign npr = {1'b0, num} + {34'd0, den[31:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= npr;
      den_q[0] <= den;
      quo_q[0] <= '0;
      ovf_q[0] <= {1'b0, npr[64:QW]} >= den;
    end
  end

  genvar i;
  generate
    for (i = 0; i < QW; i++) begin : g_stage
      localparam int K = QW - 1 - i;
      logic [65:0] dsh;
      logic        ge;
      assign dsh = {34'd0, den_q[i]} << K;
      assign ge  = {1'b0, rem_q[i]} >= dsh;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i+1] <= ge ? rem_q[i] - dsh[64:0] : rem_q[i];
          den_q[i+1] <= den_q[i];
          quo_q[i+1] <= {quo_q[i][QW-2:0], ge};
          ovf_q[i+1] <= ovf_q[i];
        end
      end
    end
  endgenerate

  assign quo = quo_q[QW];
  assign ovf = ovf_q[QW];

endmodule

`default_nettype wire

[rtl/primitive_signed_distance_weight.sv]
// Top level of the signed distance and blend weight block.
// Depends on psdw_pkg, psdw_sqrt, psdw_div and the assertion macro header.
//
// Usage:
//   Write the shape registers over cfg_we / cfg_addr / cfg_wdata while idle.
//   Feed query points on s_axis (pos_x, pos_y, pos_z); each point yields one
//   result on m_axis: distance, closest point, weight in tdata, inside flag
//   in tuser.
//   Throughput: one point per cycle while the output register is empty or
//   m_axis_tready is high. The 32-stage square root and the 35-stage
//   rounding dividers lie between an accepted point and its valid result.
//   Reset clears all valid bits and loads the register defaults (box of one
//   unit, radius and height one unit, no blending).
//   When the receiver stalls, the output register holds its result and the
//   whole pipeline freezes with it, so s_axis_tready drops in the same cycle;
//   nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module primitive_signed_distance_weight (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,   // signed_distance, near_x, near_y, near_z, weight
  output logic [0:0]   m_axis_tuser    // is_inside
);

  localparam int SL = psdw_pkg::SQRT_LAT;
  localparam int DL = psdw_pkg::DIV_LAT;

  // ---------------- configuration ----------------
  logic [1:0]  shape_kind;
  logic [30:0] box_size_x, box_size_y, box_size_z;
  logic [30:0] radius, capsule_height;
  logic [30:0] blend_inside, blend_outside;

  function automatic logic [30:0] at_least_one(input logic [30:0] v);
    return (v < 31'd65536) ? 31'd65536 : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind     <= psdw_pkg::KIND_BOX;
      box_size_x     <= 31'd65536;
      box_size_y     <= 31'd65536;
      box_size_z     <= 31'd65536;
      radius         <= 31'd65536;
      capsule_height <= 31'd65536;
      blend_inside   <= '0;
      blend_outside  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        psdw_pkg::REG_SHAPE_KIND:    shape_kind     <= cfg_wdata[1:0];
        psdw_pkg::REG_BOX_SIZE_X:    box_size_x     <= at_least_one(cfg_wdata);
        psdw_pkg::REG_BOX_SIZE_Y:    box_size_y     <= at_least_one(cfg_wdata);
        psdw_pkg::REG_BOX_SIZE_Z:    box_size_z     <= at_least_one(cfg_wdata);
        psdw_pkg::REG_RADIUS:        radius         <= at_least_one(cfg_wdata);
        psdw_pkg::REG_CAPSULE_H:     capsule_height <= at_least_one(cfg_wdata);
        psdw_pkg::REG_BLEND_INSIDE:  blend_inside   <= cfg_wdata;
        psdw_pkg::REG_BLEND_OUTSIDE: blend_outside  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic out_valid;
  logic en;

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage 1: clamp and deltas ----------------
  function automatic logic signed [31:0] clamp_lim(input logic signed [31:0] v,
                                                   input logic [29:0] lim);
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    logic signed [32:0] ve;
    hi = $signed({3'b000, lim});
    lo = -hi;
    ve = {v[31], v};
    if (ve > hi) begin
      return hi[31:0];
    end else if (ve < lo) begin
      return lo[31:0];
    end
    return v;
  endfunction

  logic signed [31:0] in_x, in_y, in_z;
  logic               in_sph, in_cap;
  logic [29:0]        lim_x, lim_y, lim_z;
  logic signed [31:0] c_x, c_y, c_z;
  logic signed [32:0] d_x, d_y, d_z;
  logic signed [33:0] dm_x, dm_y, dm_z, dm_xy;
  psdw_pkg::pre_t     s1_side;

  assign in_x   = s_axis_tdata[31:0];
  assign in_y   = s_axis_tdata[63:32];
  assign in_z   = s_axis_tdata[95:64];
  assign in_cap = shape_kind == psdw_pkg::KIND_CAPSULE;
  assign in_sph = (shape_kind == psdw_pkg::KIND_SPHERE) || in_cap;

  // A sphere clamps to the origin, so the delta is the point itself.
  assign lim_x = in_sph ? 30'd0 : box_size_x[30:1];
  assign lim_y = in_cap ? capsule_height[30:1] : (in_sph ? 30'd0 : box_size_y[30:1]);
  assign lim_z = in_sph ? 30'd0 : box_size_z[30:1];

  assign c_x = clamp_lim(in_x, lim_x);
  assign c_y = clamp_lim(in_y, lim_y);
  assign c_z = clamp_lim(in_z, lim_z);

  assign d_x = {in_x[31], in_x} - {c_x[31], c_x};
  assign d_y = {in_y[31], in_y} - {c_y[31], c_y};
  assign d_z = {in_z[31], in_z} - {c_z[31], c_z};

  assign dm_x  = $signed({4'd0, box_size_x[30:1]}) - $signed({2'd0, psdw_pkg::abs32(in_x)});
  assign dm_y  = $signed({4'd0, box_size_y[30:1]}) - $signed({2'd0, psdw_pkg::abs32(in_y)});
  assign dm_z  = $signed({4'd0, box_size_z[30:1]}) - $signed({2'd0, psdw_pkg::abs32(in_z)});
  assign dm_xy = (dm_x < dm_y) ? dm_x : dm_y;

  always_comb begin
    s1_side        = '0;
    s1_side.is_sph = in_sph;
    s1_side.sgn    = {d_z[32], d_y[32], d_x[32]};
    s1_side.mag_x  = d_x[32] ? 32'(-d_x) : d_x[31:0];
    s1_side.mag_y  = d_y[32] ? 32'(-d_y) : d_y[31:0];
    s1_side.mag_z  = d_z[32] ? 32'(-d_z) : d_z[31:0];
    s1_side.p_x    = in_x;
    s1_side.p_y    = in_y;
    s1_side.p_z    = in_z;
    s1_side.c_x    = c_x;
    s1_side.c_y    = c_y;
    s1_side.c_z    = c_z;
    s1_side.box_m  = (dm_z < dm_xy) ? dm_z : dm_xy;
  end

  logic           v1, v2, v3;
  psdw_pkg::pre_t s1, s2, s3;
  logic [63:0]    sq_x, sq_y, sq_z;
  logic [63:0]    sq_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 2 squares, stage 3 sums; the sum wraps at 64 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      s1     <= s1_side;
      s2     <= s1;
      sq_x   <= s1.mag_x * s1.mag_x;
      sq_y   <= s1.mag_y * s1.mag_y;
      sq_z   <= s1.mag_z * s1.mag_z;
      s3     <= s2;
      sq_sum <= sq_x + sq_y + sq_z;
    end
  end

  // ---------------- square root ----------------
  logic [31:0]    len;
  logic [SL-1:0]  vsq;
  psdw_pkg::pre_t side_sq [SL];

  psdw_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .din  (sq_sum),
    .root (len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vsq <= '0;
    end else if (en) begin
      vsq <= {vsq[SL-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_sq[0] <= s3;
      for (int k = 1; k < SL; k++) begin
        side_sq[k] <= side_sq[k-1];
      end
    end
  end

  // ---------------- post 1: distance, inside, modes ----------------
  psdw_pkg::pre_t     sq_out;
  logic signed [35:0] sd_raw;
  logic               p_inside;
  logic signed [31:0] p_sd;
  logic               len_big;
  psdw_pkg::post_t    p1_next;

  assign sq_out  = side_sq[SL-1];
  assign len_big = len > psdw_pkg::EPS_RAW;

  always_comb begin
    if (sq_out.is_sph) begin
      sd_raw   = $signed({4'd0, len}) - $signed({5'd0, radius});
      p_inside = sd_raw <= 36'sd0;
    end else begin
      // Box: within tolerance counts as inside.
      sd_raw   = len_big ? $signed({4'd0, len}) : -{{2{sq_out.box_m[33]}}, sq_out.box_m};
      p_inside = !len_big;
    end
  end

  assign p_sd = psdw_pkg::sat32(sd_raw);

  always_comb begin
    p1_next        = '0;
    p1_next.is_in  = p_inside;
    p1_next.sd     = p_sd;
    p1_next.sgn    = sq_out.sgn;
    p1_next.p_x    = sq_out.p_x;
    p1_next.p_y    = sq_out.p_y;
    p1_next.p_z    = sq_out.p_z;
    p1_next.c_x    = sq_out.c_x;
    p1_next.c_y    = sq_out.c_y;
    p1_next.c_z    = sq_out.c_z;
    if (p_inside) begin
      p1_next.near_mode = psdw_pkg::NEAR_P;
    end else if (!sq_out.is_sph) begin
      p1_next.near_mode = psdw_pkg::NEAR_C;
    end else if (len_big) begin
      p1_next.near_mode = psdw_pkg::NEAR_SCALE;
    end else begin
      p1_next.near_mode = psdw_pkg::NEAR_ZERO;
    end
    if (p_inside) begin
      if ({1'b0, blend_inside} > psdw_pkg::EPS_RAW) begin
        p1_next.w_mode = (p_sd >= 32'sd0) ? psdw_pkg::W_ZERO : psdw_pkg::W_IN_DIV;
      end else begin
        p1_next.w_mode = psdw_pkg::W_ONE;
      end
    end else begin
      p1_next.w_mode = ({1'b0, blend_outside} > psdw_pkg::EPS_RAW) ?
                       psdw_pkg::W_OUT_DIV : psdw_pkg::W_ZERO;
    end
  end

  logic            vp1, vp2;
  psdw_pkg::post_t p1, p2;
  logic [31:0]     p1_mag_x, p1_mag_y, p1_mag_z, p1_len;
  logic [62:0]     p2_num_x, p2_num_y, p2_num_z;
  logic [31:0]     p2_len;
  logic [63:0]     p2_wnum;
  logic [31:0]     p2_wden;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
      vp2 <= 1'b0;
    end else if (en) begin
      vp1 <= vsq[SL-1];
      vp2 <= vp1;
    end
  end

  // Post 2 forms the numerators and divisors of the closest-point and weight quotients.
  always_ff @(posedge clk) begin
    if (en) begin
      p1       <= p1_next;
      p1_mag_x <= sq_out.mag_x;
      p1_mag_y <= sq_out.mag_y;
      p1_mag_z <= sq_out.mag_z;
      p1_len   <= len;
      p2       <= p1;
      p2_num_x <= p1_mag_x * radius;
      p2_num_y <= p1_mag_y * radius;
      p2_num_z <= p1_mag_z * radius;
      p2_len   <= p1_len;
      p2_wnum  <= {16'd0, psdw_pkg::abs32(p1.sd), 16'd0};
      p2_wden  <= {1'b0, p1.is_in ? blend_inside : blend_outside};
    end
  end

  // ---------------- dividers ----------------
  logic [psdw_pkg::DIV_QW-1:0] q_x, q_y, q_z, q_w;
  logic                        o_x, o_y, o_z, o_w;

  psdw_div u_div_x (
    .clk (clk), .en (en), .num ({1'b0, p2_num_x}), .den (p2_len), .quo (q_x), .ovf (o_x)
  );
  psdw_div u_div_y (
    .clk (clk), .en (en), .num ({1'b0, p2_num_y}), .den (p2_len), .quo (q_y), .ovf (o_y)
  );
  psdw_div u_div_z (
    .clk (clk), .en (en), .num ({1'b0, p2_num_z}), .den (p2_len), .quo (q_z), .ovf (o_z)
  );
  psdw_div u_div_w (
    .clk (clk), .en (en), .num (p2_wnum), .den (p2_wden), .quo (q_w), .ovf (o_w)
  );

  logic [DL-1:0]   vdv;
  psdw_pkg::post_t side_dv [DL];

  always_ff @(posedge clk) begin
    if (rst) begin
      vdv <= '0;
    end else if (en) begin
      vdv <= {vdv[DL-2:0], vp2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_dv[0] <= p2;
      for (int k = 1; k < DL; k++) begin
        side_dv[k] <= side_dv[k-1];
      end
    end
  end

  // ---------------- final: sign, offset, saturate, weight ----------------
  function automatic logic signed [35:0] signed_q(input logic [psdw_pkg::DIV_QW-1:0] q,
                                                  input logic o, input logic s);
    logic signed [35:0] m;
    // An overflowed quotient is pushed past the saturation limit.
    m = o ? 36'sh400000000 : $signed({2'b00, q});
    return s ? -m : m;
  endfunction

  psdw_pkg::post_t    fo;
  logic signed [31:0] f_x, f_y, f_z;
  logic [16:0]        f_w;

  assign fo = side_dv[DL-1];

  always_comb begin
    case (fo.near_mode)
      psdw_pkg::NEAR_P: begin
        f_x = fo.p_x;
        f_y = fo.p_y;
        f_z = fo.p_z;
      end
      psdw_pkg::NEAR_C: begin
        f_x = fo.c_x;
        f_y = fo.c_y;
        f_z = fo.c_z;
      end
      psdw_pkg::NEAR_SCALE: begin
        f_x = psdw_pkg::sat32(signed_q(q_x, o_x, fo.sgn[0]));
        f_y = psdw_pkg::sat32({{4{fo.c_y[31]}}, fo.c_y} + signed_q(q_y, o_y, fo.sgn[1]));
        f_z = psdw_pkg::sat32(signed_q(q_z, o_z, fo.sgn[2]));
      end
      default: begin
        f_x = fo.c_x;
        f_y = fo.c_y;
        f_z = $signed({1'b0, radius});
      end
    endcase
  end

  always_comb begin
    case (fo.w_mode)
      psdw_pkg::W_ONE:  f_w = psdw_pkg::ONE_Q16;
      psdw_pkg::W_ZERO: f_w = 17'd0;
      psdw_pkg::W_IN_DIV: begin
        f_w = (o_w || q_w > 34'(psdw_pkg::ONE_Q16)) ? psdw_pkg::ONE_Q16 : q_w[16:0];
      end
      default: begin
        f_w = (o_w || q_w >= 34'(psdw_pkg::ONE_Q16)) ? 17'd0 : psdw_pkg::ONE_Q16 - q_w[16:0];
      end
    endcase
  end

  logic               out_inside;
  logic signed [31:0] out_sd, out_x, out_y, out_z;
  logic [16:0]        out_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vdv[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside <= fo.is_in;
      out_sd     <= fo.sd;
      out_x      <= f_x;
      out_y      <= f_y;
      out_z      <= f_z;
      out_weight <= f_w;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_weight, out_z, out_y, out_x, out_sd};
  assign m_axis_tuser  = out_inside;

  // ---------------- assertions ----------------
  `include "primitive_signed_distance_weight_assert.svh"

  `PSDW_ASSERT_NOW(a_weight_range, clk, rst, out_valid, out_weight <= psdw_pkg::ONE_Q16, "weight above one")
  `PSDW_ASSERT_NOW(a_inside_dist, clk, rst, out_valid && out_inside, out_sd <= 32'sd6, "inside with large distance")
  `PSDW_ASSERT_NOW(a_outside_dist, clk, rst, out_valid && !out_inside, out_sd > 32'sd0, "outside with distance not positive")
  `PSDW_ASSERT_NEXT(a_accept_enters, clk, rst, s_axis_tvalid && s_axis_tready, v1, "accepted transaction missing in first stage")

endmodule

`default_nettype wire

[verif/psdw_checker.sv]
// Scoreboard for the signed distance block: watches config writes and both streams,
// predicts each result and compares it field by field. Depends on psdw_pkg.
`timescale 1ns / 1ps

module psdw_checker
  import psdw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [151:0] m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           fail_count,
  output int           awaiting,
  output int           checked
);

  typedef struct {
    bit          is_in;
    logic [31:0] sdist;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic [16:0] w;
  } dist_res_t;

  dist_res_t exp_q[$];

  logic [1:0]  kind;
  logic [30:0] size_x, size_y, size_z, rad, cap_h, fade_in, fade_out;

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absv(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned norm3(input longint a, input longint b, input longint c);
    return root64(absv(a) * absv(a) + absv(b) * absv(b) + absv(c) * absv(c));
  endfunction

  function automatic longint unsigned rdiv(input longint unsigned n, input longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  // c * r / len with rounding on the magnitude
  function automatic longint project(input longint c, input longint unsigned r,
                                     input longint unsigned len);
    longint unsigned q;
    q = rdiv(absv(c) * r, len);
    return c < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [31:0] sat(input longint v);
    return 32'(clip(v, -64'sd2147483648, 64'sd2147483647));
  endfunction

  function automatic dist_res_t predict_distance(input logic [95:0] pos);
    dist_res_t r;
    longint px, py, pz, sd, nx, ny, nz, sy, dy, hh, hx, hy, hz, cx, cy, cz, dx, dyy, dz, m;
    longint unsigned len, q, w;
    bit in_flag;
    px = longint'($signed(pos[31:0]));
    py = longint'($signed(pos[63:32]));
    pz = longint'($signed(pos[95:64]));
    nx = px; ny = py; nz = pz;
    if (kind == KIND_SPHERE || kind == KIND_CAPSULE) begin
      sy = 0;
      dy = py;
      if (kind == KIND_CAPSULE) begin
        hh = longint'(cap_h >> 1);
        sy = clip(py, -hh, hh);
        dy = py - sy;
      end
      len = norm3(px, dy, pz);
      sd = longint'(len) - longint'(rad);
      in_flag = sd <= 0;
      if (!in_flag) begin
        if (len > 6) begin
          nx = project(px, rad, len);
          ny = sy + project(dy, rad, len);
          nz = project(pz, rad, len);
        end else begin
          nx = 0; ny = sy; nz = longint'(rad);
        end
      end
    end else begin
      hx = longint'(size_x >> 1);
      hy = longint'(size_y >> 1);
      hz = longint'(size_z >> 1);
      cx = clip(px, -hx, hx);
      cy = clip(py, -hy, hy);
      cz = clip(pz, -hz, hz);
      len = norm3(px - cx, py - cy, pz - cz);
      if (len > 6) begin
        in_flag = 0;
        sd = longint'(len);
        nx = cx; ny = cy; nz = cz;
      end else begin
        dx = hx - longint'(absv(px));
        dyy = hy - longint'(absv(py));
        dz = hz - longint'(absv(pz));
        m = dx < dyy ? dx : dyy;
        if (dz < m) m = dz;
        in_flag = 1;
        sd = -m;
      end
    end
    r.sdist = sat(sd);
    sd = longint'($signed(r.sdist));
    if (in_flag) begin
      if (fade_in > 6) begin
        if (sd >= 0) w = 0;
        else begin
          w = rdiv(absv(sd) * 65536, fade_in);
          if (w > 65536) w = 65536;
        end
      end else w = 65536;
    end else begin
      if (fade_out > 6) begin
        q = rdiv(absv(sd) * 65536, fade_out);
        w = q >= 65536 ? 0 : 65536 - q;
      end else w = 0;
    end
    r.is_in = in_flag;
    r.nx = sat(nx);
    r.ny = sat(ny);
    r.nz = sat(nz);
    r.w = 17'(w);
    return r;
  endfunction

  function automatic logic [30:0] floor_one(input logic [30:0] v);
    return v < 31'd65536 ? 31'd65536 : v;
  endfunction

  always @(posedge clk) begin
    dist_res_t e;
    int errs;
    if (rst) begin
      kind <= KIND_BOX;
      size_x <= 31'd65536; size_y <= 31'd65536; size_z <= 31'd65536;
      rad <= 31'd65536; cap_h <= 31'd65536;
      fade_in <= '0; fade_out <= '0;
      exp_q.delete();
      fail_count <= 0;
      awaiting <= 0;
      checked <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SHAPE_KIND:    kind <= cfg_wdata[1:0];
          REG_BOX_SIZE_X:    size_x <= floor_one(cfg_wdata);
          REG_BOX_SIZE_Y:    size_y <= floor_one(cfg_wdata);
          REG_BOX_SIZE_Z:    size_z <= floor_one(cfg_wdata);
          REG_RADIUS:        rad <= floor_one(cfg_wdata);
          REG_CAPSULE_H:     cap_h <= floor_one(cfg_wdata);
          REG_BLEND_INSIDE:  fade_in <= cfg_wdata;
          REG_BLEND_OUTSIDE: fade_out <= cfg_wdata;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          fail_count <= fail_count + 1;
        end else begin
          e = exp_q.pop_front();
          errs = 0;
          checked <= checked + 1;
          if (m_axis_tuser[0] !== e.is_in) begin
            $error("is_inside: expected %0d, got %0d", e.is_in, m_axis_tuser[0]);
            errs++;
          end
          if (m_axis_tdata[31:0] !== e.sdist) begin
            $error("signed_distance: expected %0d, got %0d", $signed(e.sdist),
                   $signed(m_axis_tdata[31:0]));
            errs++;
          end
          if (m_axis_tdata[63:32] !== e.nx) begin
            $error("near_x: expected %0d, got %0d", $signed(e.nx), $signed(m_axis_tdata[63:32]));
            errs++;
          end
          if (m_axis_tdata[95:64] !== e.ny) begin
            $error("near_y: expected %0d, got %0d", $signed(e.ny), $signed(m_axis_tdata[95:64]));
            errs++;
          end
          if (m_axis_tdata[127:96] !== e.nz) begin
            $error("near_z: expected %0d, got %0d", $signed(e.nz),
                   $signed(m_axis_tdata[127:96]));
            errs++;
          end
          if (m_axis_tdata[144:128] !== e.w) begin
            $error("weight: expected %0d, got %0d", e.w, m_axis_tdata[144:128]);
            errs++;
          end
          fail_count <= fail_count + errs;
        end
      end
      if (s_axis_tvalid && s_axis_tready) exp_q.push_back(predict_distance(s_axis_tdata));
      awaiting <= exp_q.size();
    end
  end

endmodule

[verif/tb_primitive_signed_distance_weight.sv]
// Top of the signed distance testbench: clock, reset, register phases, point stimulus
// with random gaps and stalls, and the verdict. Depends on psdw_pkg, psdw_checker and the top level.
`timescale 1ns / 1ps

module tb_primitive_signed_distance_weight;
  import psdw_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [2:0]   cfg_addr = '0;
  logic [30:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [151:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  int fail_count, awaiting, checked;
  int points_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit long_hold_done = 0;

  always #6 clk = ~clk;

  primitive_signed_distance_weight DUT (.*);

  psdw_checker chk (.*);

  // Result side: mostly ready, short and occasional long stalls, one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (!long_hold_done && points_sent >= 300) begin
      long_hold_done <= 1;
      stall_left <= 400;
      m_axis_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else if ($urandom_range(0, 9) < 7) begin
      m_axis_tready <= 1;
    end else begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      m_axis_tready <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_reg(input logic [2:0] idx, input logic [30:0] value);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Drain the pipeline before touching registers.
  task automatic settle();
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_point(input longint x, input longint y, input longint z);
    int gap;
    gap = 0;
    if ($urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {32'(z), 32'(y), 32'(x)};
    do @(posedge clk); while (!s_axis_tready);
    points_sent <= points_sent + 1;
  endtask

  function automatic longint pick_coord(input longint unsigned reach, input longint unsigned edge_at);
    longint v;
    case ($urandom_range(0, 7))
      0: v = longint'($signed($urandom()));
      1: case ($urandom_range(0, 4))
           0: v = -64'sd2147483648;
           1: v = 64'sd2147483647;
           2: v = 0;
           3: v = -1;
           default: v = 1;
         endcase
      2, 3: v = longint'(edge_at) + $urandom_range(0, 16) - 8;
      default: v = longint'($urandom() % (reach + 1));
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v < -64'sd2147483648 ? -64'sd2147483648 : (v > 64'sd2147483647 ? 64'sd2147483647 : v);
  endfunction

  task automatic random_points(input int n, input longint unsigned reach,
                               input longint unsigned edge_at);
    repeat (n) send_point(pick_coord(reach, edge_at), pick_coord(reach, edge_at),
                          pick_coord(reach, edge_at));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Unit box at reset values: center, extremes, faces and the tolerance band.
    send_point(0, 0, 0);
    send_point(64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    send_point(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
    send_point(32768, 0, 0);
    send_point(0, -32768 - 6, 0);
    send_point(0, 0, 32768 + 7);
    send_point(32768 + 3, 32768 + 3, 0);
    send_point(40000, -50000, 70000);
    send_point(-1, 100, 32767);
    random_points(100, 131072, 32768);
    s_axis_tvalid <= 0;
    settle();

    put_reg(REG_BOX_SIZE_X, 31'd229376);
    put_reg(REG_BOX_SIZE_Y, 31'd65537);
    put_reg(REG_BOX_SIZE_Z, 31'd400000);
    put_reg(REG_BLEND_INSIDE, 31'd32768);
    put_reg(REG_BLEND_OUTSIDE, 31'd131072);
    random_points(110, 300000, 114688);
    s_axis_tvalid <= 0;
    settle();

    put_reg(REG_SHAPE_KIND, KIND_SPHERE);
    put_reg(REG_RADIUS, 31'd131072);
    put_reg(REG_BLEND_INSIDE, 31'd6);
    put_reg(REG_BLEND_OUTSIDE, 31'd7);
    send_point(0, 0, 0);
    send_point(0, 0, 131072);
    send_point(131072 + 5, 0, 0);
    send_point(-100000, 100000, -3);
    send_point(64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
    random_points(110, 300000, 131072);
    s_axis_tvalid <= 0;
    settle();

    put_reg(REG_SHAPE_KIND, KIND_CAPSULE);
    put_reg(REG_RADIUS, 31'd98304);
    put_reg(REG_CAPSULE_H, 31'd196608);
    put_reg(REG_BLEND_INSIDE, 31'd65536);
    put_reg(REG_BLEND_OUTSIDE, 31'd65536);
    send_point(0, 200000, 0);
    send_point(0, -98304, 50000);
    send_point(98304, 98304, 0);
    random_points(110, 400000, 98304);
    s_axis_tvalid <= 0;
    settle();

    put_reg(REG_SHAPE_KIND, KIND_BOX);
    put_reg(REG_BOX_SIZE_X, 31'h7FFFFFFF);
    put_reg(REG_BOX_SIZE_Y, 31'h7FFFFFFF);
    put_reg(REG_BOX_SIZE_Z, 31'h7FFFFFFF);
    put_reg(REG_BLEND_INSIDE, 31'h7FFFFFFF);
    put_reg(REG_BLEND_OUTSIDE, 31'h7FFFFFFF);
    random_points(110, 64'd2147483647, 64'd1073741823);
    s_axis_tvalid <= 0;
    settle();

    put_reg(REG_SHAPE_KIND, KIND_SPHERE);
    put_reg(REG_RADIUS, 31'h7FFFFFFF);
    put_reg(REG_BLEND_INSIDE, 31'd1);
    put_reg(REG_BLEND_OUTSIDE, 31'd1);
    random_points(110, 64'd2147483647, 64'd2147483647);
    s_axis_tvalid <= 0;
    settle();

    // Sizes below one unit get raised to one unit.
    put_reg(REG_SHAPE_KIND, KIND_CAPSULE);
    put_reg(REG_RADIUS, 31'd0);
    put_reg(REG_CAPSULE_H, 31'd1000);
    put_reg(REG_BLEND_INSIDE, 31'h7FFFFFFF);
    put_reg(REG_BLEND_OUTSIDE, 31'h7FFFFFFF);
    random_points(110, 200000, 65536);
    s_axis_tvalid <= 0;
    settle();

    // The unused selector value falls back to the box.
    put_reg(REG_SHAPE_KIND, KIND_UNUSED);
    put_reg(REG_BOX_SIZE_X, 31'd0);
    put_reg(REG_BOX_SIZE_Y, 31'd65535);
    put_reg(REG_BOX_SIZE_Z, 31'd70000);
    put_reg(REG_BLEND_INSIDE, 31'd256);
    put_reg(REG_BLEND_OUTSIDE, 31'd256);
    random_points(110, 100000, 32768);
    s_axis_tvalid <= 0;

    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("tb: %0d points sent, %0d results compared", points_sent, checked);
    $display("tb: box, sphere, capsule and fallback shapes, extreme sizes and blends");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
